// ----- rtl/hsv2rgb_pkg.sv -----
package hsv2rgb_pkg;

  localparam int CHANNEL_BITS = 8;
  localparam int HUE_BITS     = 13;
  localparam int FRAC_BITS    = 10;
  localparam int SECTOR_BITS  = 3;

  localparam int SECTOR_SPAN = 960;
  localparam int FULL_TURN   = 6 * SECTOR_SPAN;

  localparam logic [CHANNEL_BITS-1:0] CHAN_MAX = {CHANNEL_BITS{1'b1}};

  // Widths of the products on the q and t paths.
  localparam int PROD_BITS = CHANNEL_BITS + FRAC_BITS;
  localparam int NUM_BITS  = 2 * CHANNEL_BITS + FRAC_BITS;

  // The sector span is 64 times 15; the factor 15 is divided by a reciprocal.
  localparam int SPAN_SHIFT  = 6;
  localparam int SCALED_BITS = NUM_BITS - SPAN_SHIFT;
  localparam int RECIP_SHIFT = 2 * CHANNEL_BITS + 8;
  localparam int RECIP_BITS  = 2 * CHANNEL_BITS + 5;
  localparam int MULT_BITS   = SCALED_BITS + RECIP_BITS;
  localparam logic [RECIP_BITS-1:0] RECIP =
    RECIP_BITS'(((64'd1 << RECIP_SHIFT) + 64'd14) / 64'd15);

  localparam logic [PROD_BITS-1:0] SPAN_MAX =
    PROD_BITS'(SECTOR_SPAN * ((2 ** CHANNEL_BITS) - 1));

  typedef struct packed {
    logic mul;
    logic fix;
  } stage_en_t;

  // Exact floor(x / CHAN_MAX) for x up to CHAN_MAX squared. The shift gives the
  // quotient or one less, and the remainder decides which.
  function automatic logic [CHANNEL_BITS-1:0] div_by_max(
    input logic [2*CHANNEL_BITS-1:0] x
  );
    logic [CHANNEL_BITS-1:0] qa;
    logic [CHANNEL_BITS:0]   rem;
    qa  = x[2*CHANNEL_BITS-1:CHANNEL_BITS];
    rem = {1'b0, x[CHANNEL_BITS-1:0]} + {1'b0, qa};
    if (rem >= {1'b0, CHAN_MAX}) begin
      div_by_max = qa + CHANNEL_BITS'(1);
    end else begin
      div_by_max = qa;
    end
  endfunction

endpackage

// ----- rtl/hsv_to_rgb_converter.sv -----
// Channel  Direction  Handshake             Payload
// input    in         in_valid / in_ready   hue, saturation, brightness
// output   out        out_valid / out_ready red_out, green_out, blue_out
//
// Every transaction passes through eight register stages; its result is registered
// in stage 8 and shown on the output until it is taken. One transaction is accepted
// per cycle unless a stall at the output has filled every stage; the reciprocal
// multiply and its correction in each divider take stages six and seven. Reset
// clears only the stage valid bits. A stall at the output holds each full stage that
// has only full stages after it, while the other stages keep moving.
module hsv_to_rgb_converter
  import hsv2rgb_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [HUE_BITS-1:0]     hue,
  input  logic [CHANNEL_BITS-1:0] saturation,
  input  logic [CHANNEL_BITS-1:0] brightness,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [CHANNEL_BITS-1:0] red_out,
  output logic [CHANNEL_BITS-1:0] green_out,
  output logic [CHANNEL_BITS-1:0] blue_out
);

  localparam logic [SECTOR_BITS-1:0] SEC_RED     = 3'd0;
  localparam logic [SECTOR_BITS-1:0] SEC_YELLOW  = 3'd1;
  localparam logic [SECTOR_BITS-1:0] SEC_GREEN   = 3'd2;
  localparam logic [SECTOR_BITS-1:0] SEC_CYAN    = 3'd3;
  localparam logic [SECTOR_BITS-1:0] SEC_BLUE    = 3'd4;
  localparam logic [SECTOR_BITS-1:0] SEC_MAGENTA = 3'd5;

  localparam logic [HUE_BITS-1:0] TURN  = HUE_BITS'(FULL_TURN);
  localparam logic [HUE_BITS-1:0] SPAN1 = HUE_BITS'(SECTOR_SPAN);
  localparam logic [HUE_BITS-1:0] SPAN2 = HUE_BITS'(2 * SECTOR_SPAN);
  localparam logic [HUE_BITS-1:0] SPAN3 = HUE_BITS'(3 * SECTOR_SPAN);
  localparam logic [HUE_BITS-1:0] SPAN4 = HUE_BITS'(4 * SECTOR_SPAN);
  localparam logic [HUE_BITS-1:0] SPAN5 = HUE_BITS'(5 * SECTOR_SPAN);
  localparam logic [FRAC_BITS-1:0] FRAC_SPAN = FRAC_BITS'(SECTOR_SPAN);

  logic [8:1] vld;
  logic [8:1] vld_in;
  logic [8:1] en;

  logic [HUE_BITS-1:0]       h1;
  logic [CHANNEL_BITS-1:0]   s1, v1;
  logic [2*CHANNEL_BITS-1:0] pm1;

  logic [SECTOR_BITS-1:0]  sec_next;
  logic [HUE_BITS-1:0]     base_next;
  logic [HUE_BITS-1:0]     h_diff;
  logic [SECTOR_BITS-1:0]  sec2;
  logic [FRAC_BITS-1:0]    f2;
  logic [CHANNEL_BITS-1:0] s2, v2, p2;

  logic [SECTOR_BITS-1:0]  sec3, sec4, sec5, sec6, sec7;
  logic [CHANNEL_BITS-1:0] v3, v4, v5, v6, v7;
  logic [CHANNEL_BITS-1:0] p3, p4, p5, p6, p7;
  logic [PROD_BITS-1:0]    sf3, sg3, nq4, nt4;
  logic [NUM_BITS-1:0]     xq5, xt5;
  logic [CHANNEL_BITS-1:0] q7, t7;
  logic [CHANNEL_BITS-1:0] v8;

  stage_en_t div_en;

  assign vld_in = {vld[7:1], in_valid};

  always_comb begin
    en[8] = !vld[8] || out_ready;
    for (int i = 7; i >= 1; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  assign in_ready  = en[1];
  assign out_valid = vld[8];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int i = 1; i <= 8; i++) begin
        if (en[i]) begin
          vld[i] <= vld_in[i];
        end
      end
    end
  end

  // Stage 1: wrap the hue and form v * (1 - s).
  always_ff @(posedge clk) begin
    if (en[1]) begin
      h1  <= (hue >= TURN) ? hue - TURN : hue;
      s1  <= saturation;
      v1  <= brightness;
      pm1 <= (2*CHANNEL_BITS)'(brightness) * (2*CHANNEL_BITS)'(CHAN_MAX - saturation);
    end
  end

  // Stage 2: sector, offset within it, and p.
  always_comb begin
    if (h1 >= SPAN5) begin
      sec_next  = SEC_MAGENTA;
      base_next = SPAN5;
    end else if (h1 >= SPAN4) begin
      sec_next  = SEC_BLUE;
      base_next = SPAN4;
    end else if (h1 >= SPAN3) begin
      sec_next  = SEC_CYAN;
      base_next = SPAN3;
    end else if (h1 >= SPAN2) begin
      sec_next  = SEC_GREEN;
      base_next = SPAN2;
    end else if (h1 >= SPAN1) begin
      sec_next  = SEC_YELLOW;
      base_next = SPAN1;
    end else begin
      sec_next  = SEC_RED;
      base_next = '0;
    end
  end

  assign h_diff = h1 - base_next;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      sec2 <= sec_next;
      f2   <= h_diff[FRAC_BITS-1:0];
      s2   <= s1;
      v2   <= v1;
      p2   <= div_by_max(pm1);
    end
  end

  // Stage 3: s * f and s * (1 - f).
  always_ff @(posedge clk) begin
    if (en[3]) begin
      sec3 <= sec2;
      v3   <= v2;
      p3   <= p2;
      sf3  <= PROD_BITS'(s2) * PROD_BITS'(f2);
      sg3  <= PROD_BITS'(s2) * PROD_BITS'(FRAC_SPAN - f2);
    end
  end

  // Stage 4: numerators of q and t before scaling by v.
  always_ff @(posedge clk) begin
    if (en[4]) begin
      sec4 <= sec3;
      v4   <= v3;
      p4   <= p3;
      nq4  <= SPAN_MAX - sf3;
      nt4  <= SPAN_MAX - sg3;
    end
  end

  // Stage 5: scale by v.
  always_ff @(posedge clk) begin
    if (en[5]) begin
      sec5 <= sec4;
      v5   <= v4;
      p5   <= p4;
      xq5  <= NUM_BITS'(v4) * NUM_BITS'(nq4);
      xt5  <= NUM_BITS'(v4) * NUM_BITS'(nt4);
    end
  end

  // Stages 6 and 7: divide by the sector span times full scale.
  assign div_en.mul = en[6];
  assign div_en.fix = en[7];

  hsv2rgb_div u_div_q (
    .clk (clk),
    .en  (div_en),
    .num (xq5),
    .quo (q7)
  );

  hsv2rgb_div u_div_t (
    .clk (clk),
    .en  (div_en),
    .num (xt5),
    .quo (t7)
  );

  always_ff @(posedge clk) begin
    if (en[6]) begin
      sec6 <= sec5;
      v6   <= v5;
      p6   <= p5;
    end
  end

  always_ff @(posedge clk) begin
    if (en[7]) begin
      sec7 <= sec6;
      v7   <= v6;
      p7   <= p6;
    end
  end

  // Stage 8: order the terms onto the color channels.
  always_ff @(posedge clk) begin
    if (en[8]) begin
      v8 <= v7;
      case (sec7)
        SEC_RED: begin
          red_out <= v7; green_out <= t7; blue_out <= p7;
        end
        SEC_YELLOW: begin
          red_out <= q7; green_out <= v7; blue_out <= p7;
        end
        SEC_GREEN: begin
          red_out <= p7; green_out <= v7; blue_out <= t7;
        end
        SEC_CYAN: begin
          red_out <= p7; green_out <= q7; blue_out <= v7;
        end
        SEC_BLUE: begin
          red_out <= t7; green_out <= p7; blue_out <= v7;
        end
        default: begin
          red_out <= v7; green_out <= p7; blue_out <= q7;
        end
      endcase
    end
  end

  a_full_when_blocked: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (&vld))
    else $error("input blocked while the pipeline has an empty stage");

  a_p_is_least: assert property (@(posedge clk) disable iff (rst)
    vld[7] |-> (p7 <= q7 && p7 <= t7))
    else $error("p term exceeds q or t");

  a_one_channel_is_v: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (red_out == v8 || green_out == v8 || blue_out == v8))
    else $error("no channel carries the value term");

  a_channels_below_v: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (red_out <= v8 && green_out <= v8 && blue_out <= v8))
    else $error("a channel exceeds the value term");

endmodule

// ----- rtl/hsv2rgb_div.sv -----
module hsv2rgb_div
  import hsv2rgb_pkg::*;
(
  input  logic                    clk,
  input  stage_en_t               en,
  input  logic [NUM_BITS-1:0]     num,
  output logic [CHANNEL_BITS-1:0] quo
);

  logic [MULT_BITS-1:0]      prod;
  logic [SCALED_BITS-1:0]    scaled;
  logic [2*CHANNEL_BITS-1:0] span_quo;

  assign scaled   = num[NUM_BITS-1:SPAN_SHIFT];
  assign span_quo = prod[RECIP_SHIFT+2*CHANNEL_BITS-1:RECIP_SHIFT];

  always_ff @(posedge clk) begin
    if (en.mul) begin
      prod <= MULT_BITS'(scaled) * MULT_BITS'(RECIP);
    end
  end

  always_ff @(posedge clk) begin
    if (en.fix) begin
      quo <= div_by_max(span_quo);
    end
  end

endmodule
